FILE: src/crb_pkg.sv
// Shared types, widths and constants of the cubic bisection root finder.
package crb_pkg;

	// Fixed field widths
	localparam int unsigned XW       = 26;  // interval end and root estimate
	localparam int unsigned TOLW     = 25;  // tolerance register
	localparam int unsigned STEPW    = 10;  // iteration limit and step count
	localparam int unsigned COEFW    = 32;  // polynomial coefficients
	localparam int unsigned ACCW     = 64;  // Horner accumulator
	localparam int unsigned HALFW    = ACCW / 2;
	localparam int unsigned MULAW    = HALFW + 1;
	localparam int unsigned MULPW    = MULAW + XW;
	localparam int unsigned REGIDXW  = 3;
	localparam int unsigned WDATAW   = 32;

	// Default fraction bits of the fixed point format
	localparam int unsigned FRACTION_BITS_DEF = 16;

	// Register indexes of the write port
	typedef enum logic [REGIDXW-1:0] {
		REG_TOLERANCE       = 3'd0,
		REG_ITERATION_LIMIT = 3'd1,
		REG_COEFF_CUBIC     = 3'd2,
		REG_COEFF_SQUARE    = 3'd3,
		REG_COEFF_LINEAR    = 3'd4,
		REG_COEFF_CONSTANT  = 3'd5
	} reg_idx_t;

	// Register reset values
	localparam logic [TOLW-1:0]         TOL_RST   = TOLW'(66);
	localparam logic [STEPW-1:0]        LIMIT_RST = STEPW'(1000);
	localparam logic signed [COEFW-1:0] C3_RST    = COEFW'(65536);
	localparam logic signed [COEFW-1:0] C2_RST    = -COEFW'(131072);
	localparam logic signed [COEFW-1:0] C1_RST    = -COEFW'(393216);
	localparam logic signed [COEFW-1:0] C0_RST    = -COEFW'(65536);

	// Horner term index: which coefficient is added after a multiply
	typedef enum logic [1:0] {
		TERM_SQUARE   = 2'd0,
		TERM_LINEAR   = 2'd1,
		TERM_CONSTANT = 2'd2
	} term_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_SIGN,
		ST_DONE
	} state_t;

endpackage

FILE: src/cubic_root_bisection_core.sv
// Bisection root finder for a cubic polynomial, with one shared multiplier.
//
// channel  | direction | handshake           | word
// ---------+-----------+---------------------+-----------------------------------------
// in       | input     | in_valid/in_ready   | lower_bound, upper_bound
// out      | output    | out_valid/out_ready | root_estimate, steps_taken, limit_hit
// config   | input     | write_en            | write_index, write_data
//
// One evaluation of f runs three Horner terms, each a low-half multiply, a high-half
// multiply and a shift and add on the one 33x26 multiplier.
// f(lower) is evaluated once per word that halves at all, and its sign is kept afterwards.
// Reset clears the sequencer, the output valid and loads the register defaults.
// The finished word waits in the output register; a new word is taken meanwhile.
module cubic_root_bisection_core
	import crb_pkg::*;
#(
	parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [XW-1:0]     lower_bound,
	input  logic signed [XW-1:0]     upper_bound,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [XW-1:0]     root_estimate,
	output logic [STEPW-1:0]         steps_taken,
	output logic                     limit_hit,
	input  logic                     write_en,
	input  logic [REGIDXW-1:0]       write_index,
	input  logic [WDATAW-1:0]        write_data
);

	state_t state_q, state_d;

	// Configuration registers
	logic [TOLW-1:0]         tol_q;
	logic [STEPW-1:0]        limit_q;
	logic signed [COEFW-1:0] c3_q, c2_q, c1_q, c0_q;

	// Interval and iteration state
	logic signed [XW-1:0]    lo_q, hi_q, x_q;
	logic [STEPW-1:0]        steps_q;
	logic                    wide_q;
	logic                    eval_mid_q;
	logic                    sl_zero_q, sl_neg_q;
	term_t                   term_q;

	// Shared multiplier and Horner registers
	logic signed [MULAW-1:0] mul_a;
	logic signed [MULPW-1:0] mul_p;
	logic signed [MULPW-1:0] part_q;
	logic signed [ACCW-1:0]  full_q;
	logic signed [ACCW-1:0]  acc_q;
	logic signed [COEFW-1:0] coef;

	// Combinational helpers
	logic signed [XW:0]      diff, sum;
	logic signed [XW-1:0]    mid;
	logic                    wide;
	logic                    start_lo, start_mid, finish, load_out;
	logic                    acc_zero, acc_neg, keep_upper;

	logic signed [XW-1:0]    root_q;
	logic [STEPW-1:0]        steps_out_q;
	logic                    limit_out_q;
	logic                    out_valid_q;

	// Interval width test and floored midpoint
	assign diff = XW'(0) + {hi_q[XW-1], hi_q} - {lo_q[XW-1], lo_q};
	assign sum  = {hi_q[XW-1], hi_q} + {lo_q[XW-1], lo_q};
	assign mid  = sum[XW:1];
	assign wide = diff >= $signed({2'b00, tol_q});

	// Sign of the finished polynomial value
	assign acc_zero   = (acc_q == '0);
	assign acc_neg    = acc_q[ACCW-1];
	assign keep_upper = sl_zero_q | acc_zero | (sl_neg_q != acc_neg);

	// Shared multiplier: one 32-bit half of the accumulator times x
	assign mul_a = (state_q == ST_MUL_HI) ? {1'b0, acc_q[ACCW-1:HALFW]}
	                                      : {1'b0, acc_q[HALFW-1:0]};
	assign mul_p = mul_a * x_q;

	// Coefficient added after the current multiply
	always_comb begin
		unique case (term_q)
			TERM_SQUARE:   coef = c2_q;
			TERM_LINEAR:   coef = c1_q;
			TERM_CONSTANT: coef = c0_q;
			default:       coef = c0_q;
		endcase
	end

	// Next state and control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		start_lo  = 1'b0;
		start_mid = 1'b0;
		finish    = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (wide && (steps_q < limit_q)) begin
					start_lo  = (steps_q == '0) && !eval_mid_q;
					start_mid = !start_lo;
					state_d   = ST_MUL_LO;
				end else begin
					finish  = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_ACC;
			ST_ACC: begin
				state_d = (term_q == TERM_CONSTANT) ? ST_SIGN : ST_MUL_LO;
			end
			ST_SIGN: state_d = ST_CHECK;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RST;
			limit_q <= LIMIT_RST;
			c3_q    <= C3_RST;
			c2_q    <= C2_RST;
			c1_q    <= C1_RST;
			c0_q    <= C0_RST;
		end else if (write_en) begin
			case (write_index)
				REG_TOLERANCE:       tol_q   <= write_data[TOLW-1:0];
				REG_ITERATION_LIMIT: limit_q <= write_data[STEPW-1:0];
				REG_COEFF_CUBIC:     c3_q    <= $signed(write_data);
				REG_COEFF_SQUARE:    c2_q    <= $signed(write_data);
				REG_COEFF_LINEAR:    c1_q    <= $signed(write_data);
				REG_COEFF_CONSTANT:  c0_q    <= $signed(write_data);
				default: ;
			endcase
		end
	end

	// Interval, step count and cached sign of f(lower)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q       <= '0;
			hi_q       <= '0;
			x_q        <= '0;
			steps_q    <= '0;
			eval_mid_q <= 1'b0;
			wide_q     <= 1'b0;
			sl_zero_q  <= 1'b0;
			sl_neg_q   <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				lo_q       <= lower_bound;
				hi_q       <= upper_bound;
				steps_q    <= '0;
				eval_mid_q <= 1'b0;
			end
			if (finish) wide_q <= wide;
			if (start_lo) x_q <= lo_q;
			if (start_mid) x_q <= mid;
			if (state_q == ST_SIGN) begin
				if (!eval_mid_q) begin
					// f(lower) known; every later evaluation is at a midpoint
					sl_zero_q  <= acc_zero;
					sl_neg_q   <= acc_neg;
					eval_mid_q <= 1'b1;
				end else begin
					steps_q <= steps_q + STEPW'(1);
					if (keep_upper) begin
						hi_q <= x_q;
					end else begin
						lo_q      <= x_q;
						sl_zero_q <= acc_zero;
						sl_neg_q  <= acc_neg;
					end
				end
			end
		end
	end

	// Horner datapath: two half multiplies, then shift and add the coefficient
	always_ff @(posedge clk) begin
		if (start_lo || start_mid) begin
			acc_q  <= {{(ACCW-COEFW){c3_q[COEFW-1]}}, c3_q};
			term_q <= TERM_SQUARE;
		end
		if (state_q == ST_MUL_LO) part_q <= mul_p;
		if (state_q == ST_MUL_HI) begin
			full_q <= {{(ACCW-MULPW){part_q[MULPW-1]}}, part_q}
			        + {mul_p[HALFW-1:0], {HALFW{1'b0}}};
		end
		if (state_q == ST_ACC) begin
			acc_q <= (full_q >>> FRACTION_BITS)
			       + $signed({{(ACCW-COEFW){coef[COEFW-1]}}, coef});
			unique case (term_q)
				TERM_SQUARE:   term_q <= TERM_LINEAR;
				TERM_LINEAR:   term_q <= TERM_CONSTANT;
				TERM_CONSTANT: term_q <= TERM_CONSTANT;
				default:       term_q <= TERM_CONSTANT;
			endcase
		end
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			root_q      <= mid;
			steps_out_q <= steps_q;
			limit_out_q <= wide_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign root_estimate = root_q;
	assign steps_taken   = steps_out_q;
	assign limit_hit     = limit_out_q;

`ifndef NO_ASSERTIONS
	// An accepted word always starts with the width test
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CHECK)
		else $error("accepted word did not enter the width test");

	// The step count never passes the limit while a word is in work
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_DONE) |-> steps_q <= limit_q)
		else $error("step count beyond iteration limit");

	// Halving keeps the interval ordered
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN && eval_mid_q) |-> lo_q <= hi_q)
		else $error("interval ends out of order during halving");

	// A new result appears only from the finishing state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the finishing state");
`endif

endmodule

FILE: tb/tb_cubic_root_bisection_core.sv
// Self-checking testbench for the cubic bisection root finder core.
`timescale 1ns / 1ps

module tb_cubic_root_bisection_core;
	import crb_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int FRAC = FRACTION_BITS_DEF;
	localparam int ONE = 1 << FRAC;
	localparam int SPAN_MAX = 16777216;

	// Indexes that map to no register; writes to them must be ignored
	localparam logic [REGIDXW-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [REGIDXW-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic signed [XW-1:0] root;
		logic [STEPW-1:0]     steps;
		logic                 hit;
	} root_word_t;

	// Register copy, bisection predictor and queue of roots still owed by the core
	class root_tracker;
		logic [TOLW-1:0]  tol;
		logic [STEPW-1:0] lim;
		longint           c3, c2, c1, c0;
		root_word_t       pending_roots[$];
		int               mismatches;

		function new();
			tol = TOL_RST;
			lim = LIMIT_RST;
			c3 = C3_RST;
			c2 = C2_RST;
			c1 = C1_RST;
			c0 = C0_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic [REGIDXW-1:0] idx, logic [WDATAW-1:0] data);
			case (idx)
				REG_TOLERANCE:       tol = data[TOLW-1:0];
				REG_ITERATION_LIMIT: lim = data[STEPW-1:0];
				REG_COEFF_CUBIC:     c3 = longint'($signed(data));
				REG_COEFF_SQUARE:    c2 = longint'($signed(data));
				REG_COEFF_LINEAR:    c1 = longint'($signed(data));
				REG_COEFF_CONSTANT:  c0 = longint'($signed(data));
				default: ;
			endcase
		endfunction

		// Horner evaluation with 64-bit wrap and flooring shift; keep only the sign
		function int cubic_sign(longint x);
			longint acc;
			acc = c3;
			acc = ((acc * x) >>> FRAC) + c2;
			acc = ((acc * x) >>> FRAC) + c1;
			acc = ((acc * x) >>> FRAC) + c0;
			if (acc == 0)
				return 0;
			return (acc < 0) ? -1 : 1;
		endfunction

		function void note_interval(logic signed [XW-1:0] lo_in, logic signed [XW-1:0] hi_in);
			longint lo, hi, mid, tolv;
			int steps;
			bit wide;
			root_word_t word;
			lo = lo_in;
			hi = hi_in;
			tolv = longint'(tol);
			steps = 0;
			wide = (hi - lo) >= tolv;
			// halve while the interval is wide and the step budget lasts
			while (wide && steps < int'(lim)) begin
				mid = (lo + hi) >>> 1;
				if (cubic_sign(lo) * cubic_sign(mid) <= 0)
					hi = mid;
				else
					lo = mid;
				steps++;
				wide = (hi - lo) >= tolv;
			end
			word.root = XW'((lo + hi) >>> 1);
			word.steps = STEPW'(steps);
			word.hit = wide;
			pending_roots.push_back(word);
		endfunction

		function void check_root(logic signed [XW-1:0] root, logic [STEPW-1:0] steps,
			logic hit);
			root_word_t want;
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected word, root_estimate %0d", $time, root);
				mismatches++;
				return;
			end
			want = pending_roots.pop_front();
			if (root !== want.root) begin
				$display("%0t: root_estimate expected %0d got %0d", $time, want.root, root);
				mismatches++;
			end
			if (steps !== want.steps) begin
				$display("%0t: steps_taken expected %0d got %0d", $time, want.steps, steps);
				mismatches++;
			end
			if (hit !== want.hit) begin
				$display("%0t: limit_hit expected %0d got %0d", $time, want.hit, hit);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_roots.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [XW-1:0]    lower_bound = '0;
	logic signed [XW-1:0]    upper_bound = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [XW-1:0]    root_estimate;
	logic [STEPW-1:0]        steps_taken;
	logic                    limit_hit;
	logic                    write_en = 1'b0;
	logic [REGIDXW-1:0]      write_index = REG_TOLERANCE;
	logic [WDATAW-1:0]       write_data = '0;

	root_tracker tracker;
	bit steady_flow = 1'b0;
	bit long_hold_req = 1'b0;

	cubic_root_bisection_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.lower_bound   (lower_bound),
		.upper_bound   (upper_bound),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.root_estimate (root_estimate),
		.steps_taken   (steps_taken),
		.limit_hit     (limit_hit),
		.write_en      (write_en),
		.write_index   (write_index),
		.write_data    (write_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Mostly no gap, often a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one interval word and hold it until the core takes it
	task automatic send_interval(input int lo, input int hi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		lower_bound <= XW'(lo);
		upper_bound <= XW'(hi);
		do @(posedge clk); while (!in_ready);
		tracker.note_interval(XW'(lo), XW'(hi));
	endtask

	// Log-spread widths, some reversed, some with every field bit random
	task automatic random_interval(output int lo, output int hi);
		int pick, base, span;
		pick = $urandom_range(0, 99);
		base = int'($urandom_range(0, 2 * SPAN_MAX)) - SPAN_MAX;
		span = int'($urandom_range(0, 1 << $urandom_range(0, 25)));
		if (pick < 8) begin
			lo = int'($urandom);
			hi = int'($urandom);
		end else if (pick < 16) begin
			lo = base;
			hi = base - span;
		end else begin
			lo = base;
			hi = base + span;
		end
	endtask

	task automatic run_random(input int count);
		int lo, hi;
		for (int i = 0; i < count; i++) begin
			random_interval(lo, hi);
			send_interval(lo, hi);
		end
	endtask

	// Drain the core, then write every register plus one unmapped index
	task automatic apply_setting(input logic [TOLW-1:0] tol, input logic [STEPW-1:0] lim,
		input logic [COEFW-1:0] c3, input logic [COEFW-1:0] c2,
		input logic [COEFW-1:0] c1, input logic [COEFW-1:0] c0);
		logic [REGIDXW-1:0] idx [7];
		logic [WDATAW-1:0]  val [7];
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		idx = '{REG_TOLERANCE, REG_ITERATION_LIMIT, REG_COEFF_CUBIC, REG_COEFF_SQUARE,
			REG_COEFF_LINEAR, REG_COEFF_CONSTANT, REG_SPARE_6};
		if ($urandom_range(0, 1))
			idx[6] = REG_SPARE_7;
		// junk above the narrow registers must be dropped by the core
		val = '{{7'($urandom), tol}, {22'($urandom), lim}, c3, c2, c1, c0, $urandom};
		for (int i = 0; i < 7; i++) begin
			write_en <= 1'b1;
			write_index <= idx[i];
			write_data <= val[i];
			@(posedge clk);
			tracker.set_reg(idx[i], val[i]);
		end
		write_en <= 1'b0;
	endtask

	function automatic logic [COEFW-1:0] random_coeff();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return COEFW'(int'($urandom_range(0, 8 * ONE)) - 4 * ONE);
	endfunction

	// Result side: random stalls, long hold-off on request, check each word taken
	initial begin
		int stall_left;
		int gap;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_root(root_estimate, steps_taken, limit_hit);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = 2000;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					stall_left = gap - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic [TOLW-1:0]  tol;
		logic [STEPW-1:0] lim;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: x^3 - 2x^2 - 6x - 1, tolerance 66, limit 1000
		send_interval(-SPAN_MAX, SPAN_MAX);
		send_interval(0, 5 * ONE);
		send_interval(-2 * ONE, -ONE);
		send_interval(-ONE, 0);
		send_interval(SPAN_MAX, -SPAN_MAX);
		send_interval(5, -7);
		send_interval(-(1 << 25), (1 << 25) - 1);
		send_interval((1 << 25) - 1, -(1 << 25));
		send_interval(1000, 1066);
		send_interval(1000, 1065);
		send_interval(-SPAN_MAX, -SPAN_MAX);
		send_interval(SPAN_MAX, SPAN_MAX);
		send_interval(-3, SPAN_MAX);
		send_interval(10 * ONE, 20 * ONE);

		// finest nonzero tolerance, largest limit
		apply_setting(TOLW'(1), STEPW'(1023), C3_RST, C2_RST, C1_RST, C0_RST);
		run_random(100);

		// tolerance of SPAN_MAX, single step
		apply_setting(TOLW'(SPAN_MAX), STEPW'(1), C3_RST, C2_RST, C1_RST, C0_RST);
		run_random(40);

		// tolerance at the top of its field
		apply_setting({TOLW{1'b1}}, STEPW'(1023), C3_RST, C2_RST, C1_RST, C0_RST);
		run_random(20);

		// zero tolerance: only the step limit stops an ordered interval
		apply_setting(TOLW'(0), STEPW'($urandom_range(1, 40)), random_coeff(),
			random_coeff(), random_coeff(), random_coeff());
		run_random(60);
		apply_setting(TOLW'(0), STEPW'(1023), C3_RST, C2_RST, C1_RST, C0_RST);
		run_random(4);

		// zero limit: no halving at all
		apply_setting(TOLW'($urandom_range(0, 4096)), STEPW'(0), C3_RST, C2_RST,
			C1_RST, C0_RST);
		run_random(30);

		// f(x) = x^3 hits exact zeros at the ends and at midpoints
		apply_setting(TOLW'(66), STEPW'(1000), COEFW'(ONE), '0, '0, '0);
		send_interval(0, ONE);
		send_interval(-ONE, ONE);
		send_interval(-ONE, 0);
		send_interval(-5, 3);
		run_random(30);

		// extreme coefficients overflow the accumulator
		apply_setting(TOLW'(1), STEPW'(1023), 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		run_random(30);
		apply_setting(TOLW'(1), STEPW'(1023), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		run_random(30);

		// random settings; one without idling, one with a long result hold-off
		for (int s = 0; s < 8; s++) begin
			case ($urandom_range(0, 2))
				0: tol = TOLW'($urandom_range(1, 4096));
				1: tol = TOLW'($urandom_range(1, SPAN_MAX));
				default: tol = TOLW'($urandom_range(1, (1 << 25) - 1));
			endcase
			lim = $urandom_range(0, 1) ? STEPW'($urandom_range(1, 12)) :
				STEPW'($urandom_range(1, 1023));
			apply_setting(tol, lim, random_coeff(), random_coeff(), random_coeff(),
				random_coeff());
			if (s == 2)
				steady_flow = 1'b1;
			if (s == 5)
				long_hold_req = 1'b1;
			run_random(45);
			steady_flow = 1'b0;
		end

		// drop the input, wait for every owed word, then let the core settle
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Hang guard
	initial begin
		#200_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
